FILE: hw/rtl/stdc_pkg.sv
// Shared types, constants and state encoding for the stick and trigger
// deadzone conditioner. No dependencies; every other file uses it by scoped
// names.
package stdc_pkg;

	localparam int TRIG_W      = 8;
	localparam int AXIS_W      = 16;
	localparam int DZ_W        = 15;
	localparam int NUM_W       = 2 * DZ_W;
	localparam int NUM_AXES    = 4;
	localparam int AXIS_IDX_W  = 2;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int DIV_STEPS   = DZ_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

	localparam logic [DZ_W-1:0] FULL_SCALE = 15'h7FFF;

	// result source codes
	localparam logic [1:0] SRC_TRIG_L  = 2'd0;
	localparam logic [1:0] SRC_TRIG_R  = 2'd1;
	localparam logic [1:0] SRC_STICK_L = 2'd2;
	localparam logic [1:0] SRC_STICK_R = 2'd3;

	typedef struct packed {
		logic [TRIG_W-1:0]        trig_left;
		logic [TRIG_W-1:0]        trig_right;
		logic signed [AXIS_W-1:0] raw_left_x;
		logic signed [AXIS_W-1:0] raw_left_y;
		logic signed [AXIS_W-1:0] raw_right_x;
		logic signed [AXIS_W-1:0] raw_right_y;
	} poll_t;

	typedef struct packed {
		logic [1:0]               source;
		logic [TRIG_W-1:0]        trigger_level;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic                     last;
	} result_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DZ_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DZ_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_STORE,
		ST_EMIT_TL,
		ST_EMIT_TR,
		ST_EMIT_L,
		ST_EMIT_R
	} state_t;

endpackage

FILE: hw/rtl/stdc_poll_if.sv
// Poll input channel: valid/ready handshake with one gamepad poll as payload.
// Depends on stdc_pkg.
interface stdc_poll_if;
	logic           valid;
	logic           ready;
	stdc_pkg::poll_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/stdc_result_if.sv
// Result output channel: valid/ready handshake with one result item.
// Depends on stdc_pkg.
interface stdc_result_if;
	logic             valid;
	logic             ready;
	stdc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/stdc_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying index and value.
// Depends on stdc_pkg.
interface stdc_cfg_if;
	logic          valid;
	logic          ready;
	stdc_pkg::cfg_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/stdc_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Needs num < den * 2**DZ_W so the quotient fits DZ_W bits. Depends on stdc_pkg.
module stdc_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  stdc_pkg::div_req_t req,
	output stdc_pkg::div_rsp_t rsp
);

	logic [stdc_pkg::DZ_W-1:0]      rem_q;
	logic [stdc_pkg::DZ_W-1:0]      low_q;
	logic [stdc_pkg::DZ_W-1:0]      den_q;
	logic [stdc_pkg::DZ_W-1:0]      quo_q;
	logic [stdc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;

	logic [stdc_pkg::DZ_W:0] trial;
	logic [stdc_pkg::DZ_W:0] diff;
	logic                    ge;

	assign trial = {rem_q, low_q[stdc_pkg::DZ_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= stdc_pkg::DIV_CNT_W'(stdc_pkg::DIV_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == stdc_pkg::DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[stdc_pkg::NUM_W-1:stdc_pkg::DZ_W];
			low_q <= req.num[stdc_pkg::DZ_W-1:0];
			den_q <= req.den;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			// remainder stays below den, so it fits back into DZ_W bits
			rem_q <= ge ? diff[stdc_pkg::DZ_W-1:0] : trial[stdc_pkg::DZ_W-1:0];
			low_q <= {low_q[stdc_pkg::DZ_W-2:0], 1'b0};
			quo_q <= {quo_q[stdc_pkg::DZ_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

FILE: hw/rtl/stick_trigger_deadzone_conditioner.sv
// Stick and trigger deadzone conditioner. Each axis outside its deadzone goes once
// through the single 15-step divider; the others skip it. Ready drops for the whole
// poll, so the next poll is taken only after its last result is loaded; results leave
// through one output register. Async reset clears deadzones, zero-sent flags, FSM.
module stick_trigger_deadzone_conditioner (
	input  logic         clk,
	input  logic         arst_n,
	stdc_poll_if.sink    poll,
	stdc_result_if.source result,
	stdc_cfg_if.sink     cfg
);

	stdc_pkg::state_t state_q, state_d;

	logic [stdc_pkg::DZ_W-1:0]       dz_q   [stdc_pkg::NUM_AXES];
	logic [stdc_pkg::AXIS_W-1:0]     raw_q  [stdc_pkg::NUM_AXES];
	logic [stdc_pkg::AXIS_W-1:0]     res_q  [stdc_pkg::NUM_AXES];
	logic [stdc_pkg::AXIS_IDX_W-1:0] axis_q;
	logic [stdc_pkg::TRIG_W-1:0]     tl_q, tr_q;
	logic                            need_l_q, need_r_q;
	logic                            left_zero_sent_q, right_zero_sent_q;

	logic                      neg_q, zero_q;
	logic [stdc_pkg::DZ_W-1:0] diff_q, den_q;

	logic                out_valid_q;
	stdc_pkg::result_t   out_data_q, out_nxt;
	logic                load, out_free, poll_take;

	stdc_pkg::div_req_t div_req;
	stdc_pkg::div_rsp_t div_rsp;

	// axis preparation
	logic [stdc_pkg::AXIS_W-1:0] raw_sel, mag16;
	logic [stdc_pkg::DZ_W-1:0]   mag, dz_sel;
	logic [stdc_pkg::AXIS_W-1:0] quo_ext, store_val;

	assign raw_sel = raw_q[axis_q];
	assign dz_sel  = dz_q[axis_q];
	assign mag16   = raw_sel[stdc_pkg::AXIS_W-1] ? (16'd0 - raw_sel) : raw_sel;
	// clamp; also catches the most negative code
	assign mag     = mag16[stdc_pkg::AXIS_W-1] ? stdc_pkg::FULL_SCALE
	                                          : mag16[stdc_pkg::DZ_W-1:0];

	assign quo_ext   = {1'b0, div_rsp.quo};
	assign store_val = zero_q ? '0 : (neg_q ? (16'd0 - quo_ext) : quo_ext);

	assign poll_take = poll.valid && poll.ready;
	assign out_free  = !out_valid_q || result.ready;

	assign div_req.start = (state_q == stdc_pkg::ST_MUL);
	// diff * 32767 as one subtract
	assign div_req.num   = {diff_q, {stdc_pkg::DZ_W{1'b0}}} - {{stdc_pkg::DZ_W{1'b0}}, diff_q};
	assign div_req.den   = den_q;

	stdc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stdc_pkg::ST_IDLE:    if (poll_take) state_d = stdc_pkg::ST_PREP;
			stdc_pkg::ST_PREP:    state_d = (mag <= dz_sel) ? stdc_pkg::ST_STORE
			                                                : stdc_pkg::ST_MUL;
			stdc_pkg::ST_MUL:     state_d = stdc_pkg::ST_DIV;
			stdc_pkg::ST_DIV:     if (div_rsp.done) state_d = stdc_pkg::ST_STORE;
			stdc_pkg::ST_STORE: begin
				if (axis_q == stdc_pkg::AXIS_IDX_W'(stdc_pkg::NUM_AXES - 1))
					state_d = stdc_pkg::ST_EMIT_TL;
				else
					state_d = stdc_pkg::ST_PREP;
			end
			stdc_pkg::ST_EMIT_TL: if (!need_l_q || load) state_d = stdc_pkg::ST_EMIT_TR;
			stdc_pkg::ST_EMIT_TR: if (!need_r_q || load) state_d = stdc_pkg::ST_EMIT_L;
			stdc_pkg::ST_EMIT_L:  if (load) state_d = stdc_pkg::ST_EMIT_R;
			stdc_pkg::ST_EMIT_R:  if (load) state_d = stdc_pkg::ST_IDLE;
			default:              state_d = stdc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		load    = 1'b0;
		out_nxt = '0;
		unique case (state_q)
			stdc_pkg::ST_EMIT_TL: begin
				out_nxt.source        = stdc_pkg::SRC_TRIG_L;
				out_nxt.trigger_level = tl_q;
				load                  = need_l_q && out_free;
			end
			stdc_pkg::ST_EMIT_TR: begin
				out_nxt.source        = stdc_pkg::SRC_TRIG_R;
				out_nxt.trigger_level = tr_q;
				load                  = need_r_q && out_free;
			end
			stdc_pkg::ST_EMIT_L: begin
				out_nxt.source = stdc_pkg::SRC_STICK_L;
				out_nxt.axis_x = res_q[0];
				out_nxt.axis_y = res_q[1];
				load           = out_free;
			end
			stdc_pkg::ST_EMIT_R: begin
				out_nxt.source = stdc_pkg::SRC_STICK_R;
				out_nxt.axis_x = res_q[2];
				out_nxt.axis_y = res_q[3];
				out_nxt.last   = 1'b1;
				load           = out_free;
			end
			default: ;
		endcase
	end

	assign poll.ready   = (state_q == stdc_pkg::ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= stdc_pkg::ST_IDLE;
			axis_q            <= '0;
			out_valid_q       <= 1'b0;
			left_zero_sent_q  <= 1'b0;
			right_zero_sent_q <= 1'b0;
			need_l_q          <= 1'b0;
			need_r_q          <= 1'b0;
			for (int i = 0; i < stdc_pkg::NUM_AXES; i++) dz_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (poll_take) begin
				axis_q            <= '0;
				need_l_q          <= (poll.data.trig_left != '0) || !left_zero_sent_q;
				need_r_q          <= (poll.data.trig_right != '0) || !right_zero_sent_q;
				left_zero_sent_q  <= (poll.data.trig_left == '0);
				right_zero_sent_q <= (poll.data.trig_right == '0);
			end else if (state_q == stdc_pkg::ST_STORE) begin
				axis_q <= axis_q + 1'b1;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			if (cfg.valid && cfg.data.index < stdc_pkg::CFG_INDEX_W'(stdc_pkg::NUM_AXES))
				dz_q[cfg.data.index[stdc_pkg::AXIS_IDX_W-1:0]] <=
					cfg.data.value[stdc_pkg::DZ_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (poll_take) begin
			tl_q     <= poll.data.trig_left;
			tr_q     <= poll.data.trig_right;
			raw_q[0] <= poll.data.raw_left_x;
			raw_q[1] <= poll.data.raw_left_y;
			raw_q[2] <= poll.data.raw_right_x;
			raw_q[3] <= poll.data.raw_right_y;
		end
		if (state_q == stdc_pkg::ST_PREP) begin
			neg_q  <= raw_sel[stdc_pkg::AXIS_W-1];
			zero_q <= (mag <= dz_sel);
			diff_q <= mag - dz_sel;
			den_q  <= stdc_pkg::FULL_SCALE - dz_sel;
		end
		if (state_q == stdc_pkg::ST_STORE)
			res_q[axis_q] <= store_val;
		if (load)
			out_data_q <= out_nxt;
	end

endmodule

FILE: hw/rtl/stdc_checker.sv
// Port-level assertions for the deadzone conditioner, bound to the top level.
// Depends on stdc_pkg and the channel interfaces of the top level.
module stdc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              poll_valid,
	input logic              poll_ready,
	input logic              res_valid,
	input logic              res_ready,
	input stdc_pkg::result_t res_data
);

	// a finished result waits until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped or changed while stalled");

	// one poll at a time: no new transfer right after one
	a_one_poll: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && poll_ready |=> !poll_ready)
		else $error("poll channel ready straight after a transfer");

	a_last_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.last |-> res_data.source == stdc_pkg::SRC_STICK_R)
		else $error("last flag on a result that is not the right stick");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_data.source == stdc_pkg::SRC_TRIG_L ||
		                res_data.source == stdc_pkg::SRC_TRIG_R)
		               ? (res_data.axis_x == '0 && res_data.axis_y == '0)
		               : (res_data.trigger_level == '0)))
		else $error("unused result fields not zero");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.axis_x != 16'sh8000 && res_data.axis_y != 16'sh8000)
		else $error("axis result outside +-32767");

endmodule

bind stick_trigger_deadzone_conditioner stdc_checker u_stdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.poll_valid (poll.valid),
	.poll_ready (poll.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_data   (result.data)
);
